// ----- rtl/core/ball_intake_sorting_sequencer_top_assert.svh -----
// ----------------------------------------------------------------------------
// ball intake sorting sequencer assertion macros
// concurrent assertion wrappers for the rtl of the block, included by bis_seq
// ----------------------------------------------------------------------------
`ifndef BALL_INTAKE_SORTING_SEQUENCER_TOP_ASSERT_SVH
`define BALL_INTAKE_SORTING_SEQUENCER_TOP_ASSERT_SVH

// plain invariant, checked at every edge outside reset
`define BIS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define BIS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BIS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/bis_pkg.sv -----
// ----------------------------------------------------------------------------
// bis_pkg
// types, codes and constants of the ball intake sorting sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_INTAKE = 3'd1,
    ST_UPTAKE = 3'd2,
    ST_EJECT  = 3'd3,
    ST_SHOOT  = 3'd4
  } seq_state_t;

  // robot mode codes
  localparam logic [1:0] MODE_DISABLED = 2'd0;
  localparam logic [1:0] MODE_AUTO     = 2'd1;
  localparam logic [1:0] MODE_TELEOP   = 2'd2;
  localparam logic [1:0] MODE_TEST     = 2'd3;

  // register indexes (byte address is 4 * index)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_ALLIANCE_BLUE  = 3'd0;
  localparam logic [2:0] REG_INTAKE_HOLD    = 3'd1;
  localparam logic [2:0] REG_UPTAKE_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_EJECT          = 3'd3;
  localparam logic [2:0] REG_SHOOT          = 3'd4;
  localparam logic [2:0] REG_SECOND_BALL    = 3'd5;

  // register reset values
  localparam logic       RST_ALLIANCE_BLUE  = 1'b0;
  localparam logic [7:0] RST_INTAKE_HOLD    = 8'd50;
  localparam logic [7:0] RST_UPTAKE_TIMEOUT = 8'd80;
  localparam logic [7:0] RST_EJECT          = 8'd30;
  localparam logic [7:0] RST_SHOOT          = 8'd90;
  localparam logic [7:0] RST_SECOND_BALL    = 8'd10;

  // drive commands
  localparam logic signed [7:0]  PCT_FULL        = 8'sd100;
  localparam logic signed [7:0]  PCT_FULL_REV    = -8'sd100;
  localparam logic signed [7:0]  PCT_OFF         = 8'sd0;
  localparam logic signed [11:0] UPTAKE_FULL     = 12'sd100;
  localparam logic signed [11:0] UPTAKE_OUTTAKE  = -12'sd60;
  localparam logic signed [11:0] UPTAKE_FEED_VEL = 12'sd1520;
  localparam logic signed [11:0] UPTAKE_OFF      = 12'sd0;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 40;

  // configuration registers
  typedef struct packed {
    logic       alliance_blue;
    logic [7:0] intake_hold_ticks;
    logic [7:0] uptake_timeout_ticks;
    logic [7:0] eject_ticks;
    logic [7:0] shoot_ticks;
    logic [7:0] second_ball_ticks;
  } cfg_t;

  // input item, first field in the highest bits
  typedef struct packed {
    logic       uptake_sensor;
    logic       blue_seen;
    logic       red_seen;
    logic       climber_retract;
    logic       shoot_request;
    logic       hooks_request;
    logic       outtake_front;
    logic       outtake_rear;
    logic       manual_override;
    logic       retract_request;
    logic       intake_request;
    logic [1:0] robot_mode;
  } in_item_t;

  // result item, first field in the highest bits
  typedef struct packed {
    logic               holding_second_ball;
    logic               holding_ball;
    logic               ready_to_shoot;
    logic               upper_stop;
    logic               lower_stop;
    logic               intake_valve;
    logic signed [11:0] uptake_drive;
    logic               uptake_velocity_mode;
    logic signed [7:0]  belt_drive;
    logic signed [7:0]  roller_drive;
    logic [2:0]         machine_state;
  } out_item_t;

  // tick counter that sticks at full scale
  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bis_cfg.sv -----
// ----------------------------------------------------------------------------
// bis_cfg
// apb register file holding the sequencer timing and alliance settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bis_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]                    pwdata,
  output logic      [31:0]                    prdata,
  output logic                                pready,
  output bis_pkg::cfg_t                       cfg
);
  import bis_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  // register writes, out-of-range indexes dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alliance_blue        <= RST_ALLIANCE_BLUE;
      cfg.intake_hold_ticks    <= RST_INTAKE_HOLD;
      cfg.uptake_timeout_ticks <= RST_UPTAKE_TIMEOUT;
      cfg.eject_ticks          <= RST_EJECT;
      cfg.shoot_ticks          <= RST_SHOOT;
      cfg.second_ball_ticks    <= RST_SECOND_BALL;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ALLIANCE_BLUE:  cfg.alliance_blue        <= pwdata[0];
        REG_INTAKE_HOLD:    cfg.intake_hold_ticks    <= pwdata[7:0];
        REG_UPTAKE_TIMEOUT: cfg.uptake_timeout_ticks <= pwdata[7:0];
        REG_EJECT:          cfg.eject_ticks          <= pwdata[7:0];
        REG_SHOOT:          cfg.shoot_ticks          <= pwdata[7:0];
        REG_SECOND_BALL:    cfg.second_ball_ticks    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_ALLIANCE_BLUE:  prdata = {31'd0, cfg.alliance_blue};
      REG_INTAKE_HOLD:    prdata = {24'd0, cfg.intake_hold_ticks};
      REG_UPTAKE_TIMEOUT: prdata = {24'd0, cfg.uptake_timeout_ticks};
      REG_EJECT:          prdata = {24'd0, cfg.eject_ticks};
      REG_SHOOT:          prdata = {24'd0, cfg.shoot_ticks};
      REG_SECOND_BALL:    prdata = {24'd0, cfg.second_ball_ticks};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/bis_seq.sv -----
// ----------------------------------------------------------------------------
// bis_seq
// conveyor sequencer state, tick counters and held drive commands;
// one tick is evaluated per accepted beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_seq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire bis_pkg::in_item_t item,
  input  wire bis_pkg::cfg_t     cfg,
  output bis_pkg::out_item_t     result
);
  import bis_pkg::*;

  `include "ball_intake_sorting_sequencer_top_assert.svh"

  // commands that hold their value between ticks
  typedef struct packed {
    logic signed [7:0]  roller;
    logic signed [7:0]  belt;
    logic               uptake_velocity_mode;
    logic signed [11:0] uptake;
    logic               valve;
  } held_t;

  seq_state_t cur_state, cur_state_next;
  seq_state_t pend_state, pend_state_next;
  logic [7:0] state_age, state_age_next;
  logic [7:0] roller_idle_age, roller_idle_age_next;
  logic [7:0] uptake_age, uptake_age_next;
  logic [7:0] second_ball_age, second_ball_age_next;
  logic       second_seen_before, second_seen_before_next;
  logic       ball_held, ball_held_next;
  logic       second_ball_held, second_ball_held_next;
  logic       hooks_latched, hooks_latched_next;
  logic [1:0] prev_mode, prev_mode_next;
  logic       feed_enable, feed_enable_next;
  held_t      held, held_next;

  logic own_ball;
  logic other_ball;
  logic outtake;
  logic ready;

  // one tick of the sequencer
  always_comb begin
    own_ball   = cfg.alliance_blue ? item.blue_seen : item.red_seen;
    other_ball = cfg.alliance_blue ? item.red_seen : item.blue_seen;
    outtake    = item.outtake_rear | item.outtake_front;

    roller_idle_age_next    = item.intake_request ? 8'd0 : sat_inc(roller_idle_age);
    hooks_latched_next      = hooks_latched | item.hooks_request;
    state_age_next          = sat_inc(state_age);
    uptake_age_next         = sat_inc(uptake_age);
    second_ball_age_next    = sat_inc(second_ball_age);
    ball_held_next          = ball_held;
    second_ball_held_next   = second_ball_held;
    second_seen_before_next = second_seen_before;
    pend_state_next         = pend_state;
    cur_state_next          = cur_state;
    feed_enable_next        = feed_enable;
    held_next               = held;

    // mode edges out of disabled
    if (item.robot_mode == MODE_AUTO && prev_mode == MODE_DISABLED) begin
      ball_held_next        = 1'b0;
      second_ball_held_next = 1'b0;
      pend_state_next       = ST_IDLE;
    end
    if (item.robot_mode == MODE_TELEOP && prev_mode == MODE_DISABLED) begin
      pend_state_next = ST_IDLE;
    end
    prev_mode_next = item.robot_mode;

    ready = ball_held_next;

    // intake valve; manual intake with retract and no climb request holds it
    if (outtake) begin
      held_next.valve = 1'b1;
    end else if (item.retract_request && !item.manual_override) begin
      held_next.valve = 1'b1;
    end else if (item.retract_request && !hooks_latched_next && !item.climber_retract) begin
      held_next.valve = held.valve;
    end else begin
      held_next.valve = 1'b0;
    end

    if (outtake) begin
      // manual outtake overrides the sequencer, rear wins
      ball_held_next                 = 1'b0;
      cur_state_next                 = ST_IDLE;
      pend_state_next                = ST_IDLE;
      held_next.belt                 = item.outtake_rear ? PCT_FULL : PCT_FULL_REV;
      held_next.roller               = PCT_FULL_REV;
      held_next.uptake_velocity_mode = 1'b0;
      held_next.uptake               = UPTAKE_OUTTAKE;
    end else begin
      if (item.shoot_request) begin
        pend_state_next = ST_SHOOT;
      end
      if (cur_state != pend_state_next) begin
        state_age_next = 8'd0;
      end
      cur_state_next = pend_state_next;

      unique case (cur_state_next)
        ST_IDLE: begin
          held_next.belt   = PCT_OFF;
          held_next.roller = PCT_OFF;
          feed_enable_next = 1'b0;
          pend_state_next  = item.intake_request ? ST_INTAKE : ST_IDLE;
        end
        ST_INTAKE: begin
          held_next.roller = item.intake_request ? PCT_FULL : PCT_OFF;
          held_next.belt   = second_ball_held_next ? PCT_OFF : PCT_FULL;
          feed_enable_next = 1'b0;
          if (!ball_held_next && own_ball) begin
            pend_state_next = ST_UPTAKE;
          end else if (other_ball) begin
            pend_state_next = ST_EJECT;
          end else if (item.intake_request ||
                       roller_idle_age_next < cfg.intake_hold_ticks) begin
            pend_state_next = ST_INTAKE;
          end else begin
            pend_state_next = ST_IDLE;
          end
        end
        ST_UPTAKE: begin
          held_next.uptake_velocity_mode = 1'b0;
          held_next.uptake               = UPTAKE_FULL;
          held_next.belt                 = PCT_FULL;
          held_next.roller               = item.intake_request ? PCT_FULL : PCT_OFF;
          // timer restarts only when a new ball comes in
          if (!ball_held_next) begin
            uptake_age_next = 8'd0;
            ball_held_next  = 1'b1;
          end
          pend_state_next = (uptake_age_next > cfg.uptake_timeout_ticks ||
                             item.uptake_sensor) ? ST_INTAKE : ST_UPTAKE;
        end
        ST_EJECT: begin
          held_next.roller = item.intake_request ? PCT_FULL : PCT_OFF;
          feed_enable_next = 1'b0;
          pend_state_next  = (state_age_next > cfg.eject_ticks) ? ST_INTAKE : ST_EJECT;
        end
        default: begin
          feed_enable_next = 1'b1;
          held_next.roller = PCT_OFF;
          if (state_age_next > cfg.shoot_ticks) begin
            pend_state_next = ST_IDLE;
          end
          ball_held_next = 1'b0;
        end
      endcase

      // uptake runs in velocity mode outside the uptake state
      if (cur_state_next != ST_UPTAKE) begin
        held_next.uptake_velocity_mode = 1'b1;
        held_next.uptake               = feed_enable_next ? UPTAKE_FEED_VEL : UPTAKE_OFF;
      end

      // second ball debounce
      if (cur_state_next != ST_UPTAKE && ball_held_next && own_ball) begin
        if (!second_seen_before) begin
          second_ball_age_next = 8'd0;
        end
        second_seen_before_next = 1'b1;
      end else begin
        second_seen_before_next = 1'b0;
      end
      second_ball_held_next = second_seen_before_next &&
                              (second_ball_age_next > cfg.second_ball_ticks);
    end

    // result beat
    result.machine_state        = cur_state_next;
    result.roller_drive         = held_next.roller;
    result.belt_drive           = held_next.belt;
    result.uptake_velocity_mode = held_next.uptake_velocity_mode;
    result.uptake_drive         = held_next.uptake;
    result.intake_valve         = held_next.valve;
    result.lower_stop           = (cur_state_next == ST_EJECT) || item.outtake_rear;
    result.upper_stop           = second_ball_held_next || (cur_state_next == ST_SHOOT) ||
                                  outtake;
    result.ready_to_shoot       = ready;
    result.holding_ball         = ball_held_next;
    result.holding_second_ball  = second_ball_held_next;
  end

  // state registers advance once per accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_state          <= ST_IDLE;
      pend_state         <= ST_IDLE;
      state_age          <= 8'd0;
      roller_idle_age    <= 8'hFF;
      uptake_age         <= 8'd0;
      second_ball_age    <= 8'd0;
      second_seen_before <= 1'b0;
      ball_held          <= 1'b0;
      second_ball_held   <= 1'b0;
      hooks_latched      <= 1'b0;
      prev_mode          <= MODE_DISABLED;
      feed_enable        <= 1'b0;
      held               <= '0;
    end else if (accept) begin
      cur_state          <= cur_state_next;
      pend_state         <= pend_state_next;
      state_age          <= state_age_next;
      roller_idle_age    <= roller_idle_age_next;
      uptake_age         <= uptake_age_next;
      second_ball_age    <= second_ball_age_next;
      second_seen_before <= second_seen_before_next;
      ball_held          <= ball_held_next;
      second_ball_held   <= second_ball_held_next;
      hooks_latched      <= hooks_latched_next;
      prev_mode          <= prev_mode_next;
      feed_enable        <= feed_enable_next;
      held               <= held_next;
    end
  end

  // checks
  `BIS_ASSERT_NEXT(a_outtake_clears, clk, rst, accept && (item.outtake_rear || item.outtake_front), !ball_held && cur_state == ST_IDLE, "outtake did not clear the held ball and state")
  `BIS_ASSERT_NEXT(a_idle_holds, clk, rst, !accept, $stable(cur_state) && $stable(ball_held) && $stable(held), "sequencer state moved without a beat")
  `BIS_ASSERT(a_second_needs_seen, clk, rst, !second_ball_held || second_seen_before, "second ball flagged without being seen")
  `BIS_ASSERT_IMPL(a_uptake_percent, clk, rst, cur_state == ST_UPTAKE, !held.uptake_velocity_mode, "uptake state left the uptake drive in velocity mode")

endmodule

`default_nettype wire

// ----- rtl/core/bis_skid.sv -----
// ----------------------------------------------------------------------------
// bis_skid
// two-entry output buffer: result register plus skid register, so the
// input side can take a beat while a result waits downstream
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_skid (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bis_pkg::out_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bis_pkg::out_item_t      out_data
);
  import bis_pkg::*;

  logic      skid_valid;
  out_item_t skid_data;
  logic      in_fire;
  logic      out_free;

  assign in_ready = !skid_valid;
  assign in_fire  = in_valid & in_ready;
  assign out_free = out_ready | !out_valid;

  // occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_fire;
      end
    end else if (in_fire) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : in_data;
    end else if (in_fire) begin
      skid_data <= in_data;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ball_intake_sorting_sequencer_top.sv -----
// ----------------------------------------------------------------------------
// ball_intake_sorting_sequencer_top
// conveyor sequencer for a ball intake: one control tick per input beat,
// one command beat per tick
//
//   channel   dir  width  content
//   s_axis    in   16     one control tick (mode, operator and sensor bits)
//   m_axis    out  40     drive, valve and status commands for the tick
//   apb       in   32     six setting registers at byte address 4 * index
//
// one beat per cycle sustained while m_axis is ready; a tick is evaluated in
// the cycle it is accepted and registered in the output or skid register.
// the output register and a skid register decouple the two sides, so
// input beats stop only when both hold a result that is not taken.
// rst is synchronous; it clears the sequencer and restores register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ball_intake_sorting_sequencer_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // robot_mode[1:0], intake_request, retract_request, manual_override,
  // outtake_rear, outtake_front, hooks_request, shoot_request,
  // climber_retract, red_seen, blue_seen, uptake_sensor, zero fill
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [bis_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // machine_state[2:0], roller_drive[7:0], belt_drive[7:0],
  // uptake_velocity_mode, uptake_drive[11:0], intake_valve, lower_stop,
  // upper_stop, ready_to_shoot, holding_ball, holding_second_ball, zero fill
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [bis_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [bis_pkg::CFG_ADDR_W-1:0]      paddr,
  input  wire logic [31:0]                         pwdata,
  output logic      [31:0]                         prdata,
  output logic                                     pready
);
  import bis_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  out_item_t tick_result;
  out_item_t out_item;
  logic      accept;

  assign in_item = s_axis_tdata[$bits(in_item_t)-1:0];
  assign accept  = s_axis_tvalid & s_axis_tready;

  // setting registers
  bis_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // tick evaluation and sequencer state
  bis_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (in_item),
    .cfg    (cfg),
    .result (tick_result)
  );

  // output register with skid
  bis_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (tick_result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_item)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - $bits(out_item_t)){1'b0}}, out_item};

endmodule

`default_nettype wire
